// File: sv/bounded_deque_sorted_list_unit_defines.svh
// Assertion macros used by the checker of this block.
`ifndef BOUNDED_DEQUE_SORTED_LIST_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_SORTED_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bdsl_pkg.sv
package bdsl_pkg;

  // Capacity of the list and width of the fill count.
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Operation codes.
  localparam logic [2:0] OP_PUSH_FRONT    = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK     = 3'd1;
  localparam logic [2:0] OP_POP_FRONT     = 3'd2;
  localparam logic [2:0] OP_POP_BACK      = 3'd3;
  localparam logic [2:0] OP_DELETE        = 3'd4;
  localparam logic [2:0] OP_SORTED_INSERT = 3'd5;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic               ld_cmp;
    logic               ins_en;
    logic               rem_en;
    logic signed [31:0] cmp_value;
    logic signed [31:0] value;
  } cell_ctrl_t;

  // Per-cell flags returned to the control logic.
  typedef struct packed {
    logic eq;
    logic gt;
    logic first;
  } cell_stat_t;

endpackage

// File: sv/bdsl_cell.sv
module bdsl_cell (
  input  logic                clk,
  input  bdsl_pkg::cell_ctrl_t ctrl,
  input  logic                hit,
  input  logic                after_in,
  output logic                after_out,
  input  logic signed [31:0]  left_data,
  input  logic signed [31:0]  right_data,
  output logic signed [31:0]  data,
  output bdsl_pkg::cell_stat_t stat
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic               eq_r;
  logic               gt_r;

  // The position token passes down the row; cells past it shift.
  assign after_out  = after_in | hit;
  assign data       = data_r;
  assign stat.eq    = eq_r;
  assign stat.gt    = gt_r;
  assign stat.first = hit & ~after_in;

  // Shift toward the back on insert, toward the front on remove.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_en) begin
      if (after_in) begin
        data_nxt = left_data;
      end else if (hit) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.rem_en) begin
      if (after_in || hit) begin
        data_nxt = right_data;
      end
    end
  end

  // Entry and compare flags against the incoming value.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctrl.ld_cmp) begin
      eq_r <= (data_r == ctrl.cmp_value);
      gt_r <= ($signed(data_r) > $signed(ctrl.cmp_value));
    end
  end

endmodule

// File: sv/bounded_deque_sorted_list_unit.sv
// An accepted item is executed in the EXEC state, which registers the result.
// No new item is taken while one executes; the cell row first registers its
// per-entry compares, then resolves the position chain and shifts.
// A pending result that is not taken holds off the next item.
// Reset (rst_n low, synchronous) empties the list and clears the handshake;
// entry contents are not reset.
module bounded_deque_sorted_list_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdsl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bdsl_pkg::out_item_t out_data
);

  localparam int DEPTH = bdsl_pkg::DEPTH;
  localparam int CNT_W = bdsl_pkg::CNT_W;

  bdsl_pkg::state_t    state_r, state_nxt;
  logic [2:0]          op_r;
  logic signed [31:0]  val_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  bdsl_pkg::out_item_t out_data_r, out_data_nxt;

  bdsl_pkg::cell_ctrl_t ctrl;
  bdsl_pkg::cell_stat_t stat_w [DEPTH];
  logic signed [31:0]   data_w [DEPTH];
  logic [DEPTH-1:0]     hit;
  logic [DEPTH:0]       chain;

  logic             accept;
  logic             exec;
  logic             empty;
  logic             full;
  logic             is_push;
  logic             is_rem;
  logic             gt_last;
  logic             first_le;
  logic [CNT_W-1:0] last_idx;
  logic signed [31:0] removed;

  assign accept    = in_valid & in_ready;
  assign exec      = (state_r == bdsl_pkg::ST_EXEC);
  assign in_ready  = (state_r == bdsl_pkg::ST_IDLE) & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign last_idx = cnt_r - 1'b1;
  assign is_push  = (op_r == bdsl_pkg::OP_PUSH_FRONT) || (op_r == bdsl_pkg::OP_PUSH_BACK)
                    || (op_r == bdsl_pkg::OP_SORTED_INSERT);
  assign is_rem   = (op_r == bdsl_pkg::OP_POP_FRONT) || (op_r == bdsl_pkg::OP_POP_BACK)
                    || (op_r == bdsl_pkg::OP_DELETE);

  // Broadcast control to the row.
  assign ctrl.ld_cmp    = accept;
  assign ctrl.cmp_value = in_data.value;
  assign ctrl.value     = val_r;
  assign ctrl.ins_en    = exec & is_push & ~full;
  assign ctrl.rem_en    = exec & is_rem & ~empty;

  // Row of cells, front at index zero.
  assign chain[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bdsl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .hit        (hit[g]),
      .after_in   (chain[g]),
      .after_out  (chain[g+1]),
      .left_data  ((g == 0) ? val_r : data_w[(g == 0) ? 0 : g-1]),
      .right_data ((g == DEPTH-1) ? data_w[g] : data_w[(g == DEPTH-1) ? g : g+1]),
      .data       (data_w[g]),
      .stat       (stat_w[g])
    );
  end

  // Sorted-insert boundary tests against the first and last entries.
  always_comb begin
    gt_last = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      gt_last = gt_last | (stat_w[k].gt & (last_idx == CNT_W'(k)));
    end
    first_le = stat_w[0].gt | stat_w[0].eq;
  end

  // Position flag for each cell; the first flagged cell is the target.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      unique case (op_r)
        bdsl_pkg::OP_PUSH_FRONT, bdsl_pkg::OP_POP_FRONT: hit[k] = (k == 0);
        bdsl_pkg::OP_PUSH_BACK:  hit[k] = (cnt_r == CNT_W'(k));
        bdsl_pkg::OP_POP_BACK:   hit[k] = (last_idx == CNT_W'(k));
        bdsl_pkg::OP_DELETE:     hit[k] = (CNT_W'(k) < cnt_r) & stat_w[k].eq;
        bdsl_pkg::OP_SORTED_INSERT: begin
          if (empty) begin
            hit[k] = (k == 0);
          end else if (!gt_last) begin
            hit[k] = (cnt_r == CNT_W'(k));
          end else if (first_le) begin
            hit[k] = (k == 0);
          end else begin
            hit[k] = (k != 0) & (CNT_W'(k) < cnt_r) & stat_w[k].gt;
          end
        end
        default: hit[k] = 1'b0;
      endcase
    end
  end

  // Word held by the target cell.
  always_comb begin
    removed = '0;
    for (int k = 0; k < DEPTH; k++) begin
      removed = removed | (data_w[k] & {32{stat_w[k].first}});
    end
  end

  // Sequencer and result formation.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      bdsl_pkg::ST_IDLE: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
        end
        if (accept) begin
          state_nxt = bdsl_pkg::ST_EXEC;
        end
      end
      bdsl_pkg::ST_EXEC: begin
        out_data_nxt.removed_value = '0;
        out_data_nxt.status        = bdsl_pkg::STAT_OK;
        if (is_push) begin
          if (full) begin
            out_data_nxt.status = bdsl_pkg::STAT_FULL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (is_rem) begin
          if (empty) begin
            out_data_nxt.status = bdsl_pkg::STAT_EMPTY;
          end else if (chain[DEPTH]) begin
            out_data_nxt.removed_value = removed;
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            out_data_nxt.status = bdsl_pkg::STAT_NOTFOUND;
          end
        end
        out_data_nxt.entry_count = 5'(cnt_nxt);
        out_valid_nxt = 1'b1;
        state_nxt     = bdsl_pkg::ST_IDLE;
      end
      default: state_nxt = bdsl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdsl_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item payload and result register.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      op_r  <= in_data.func;
      val_r <= in_data.value;
    end
  end

endmodule

// File: sv/bdsl_checker.sv
`include "bounded_deque_sorted_list_unit_defines.svh"

module bdsl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bdsl_pkg::out_item_t out_data
);

  // A result that is not taken stays put.
  `BDSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_data), "result changed while stalled")

  // An accept is never followed directly by another accept.
  `BDSL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
                    "item accepted on back-to-back cycles")

  // A refused push only happens on a full list.
  `BDSL_ASSERT_NOW(a_full_count, clk, rst_n,
                   out_valid && (out_data.status == bdsl_pkg::STAT_FULL),
                   out_data.entry_count == 5'(bdsl_pkg::DEPTH), "full status with list not full")

  // An empty report only happens on an empty list.
  `BDSL_ASSERT_NOW(a_empty_count, clk, rst_n,
                   out_valid && (out_data.status == bdsl_pkg::STAT_EMPTY),
                   out_data.entry_count == 5'd0, "empty status with entries held")

endmodule

bind bounded_deque_sorted_list_unit bdsl_checker u_bdsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/bounded_deque_sorted_list_unit_tb.sv
`timescale 1ns / 1ps

module bounded_deque_sorted_list_unit_tb;
  import bdsl_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASE_ITEMS = 320;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int MAX_REPORTS = 10;

  // Function codes the block treats as no-ops.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    in_item_t  op;
    bit        fixed;
    out_item_t res;
  } op_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow copy of the list contents, front first.
  logic signed [31:0] list_words [DEPTH];
  int                 list_len = 0;

  out_item_t pending_results [$];
  op_row_t   directed_ops [$];
  int        fail_count = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;

  bounded_deque_sorted_list_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Removes one position from the shadow list and returns its word.
  function automatic logic signed [31:0] take_word(input int pos);
    logic signed [31:0] w;
    w = list_words[pos];
    for (int k = pos; k + 1 < list_len; k++) begin
      list_words[k] = list_words[k + 1];
    end
    list_len--;
    return w;
  endfunction

  // Applies one item to the shadow list and returns the result it should give.
  function automatic out_item_t apply_list_op(input in_item_t op);
    out_item_t r;
    int        pos;
    bit        found;
    r = '0;
    r.status = STAT_OK;
    case (op.func)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (op.func == OP_PUSH_FRONT) begin
            pos = 0;
          end else if (op.func == OP_PUSH_BACK || list_len == 0) begin
            pos = list_len;
          end else if (op.value >= list_words[list_len - 1]) begin
            pos = list_len;
          end else if (op.value <= list_words[0]) begin
            pos = 0;
          end else begin
            // Just before the first entry past the front that is greater.
            pos = list_len;
            for (int k = list_len - 1; k >= 1; k--) begin
              if (list_words[k] > op.value) pos = k;
            end
          end
          for (int k = list_len; k > pos; k--) begin
            list_words[k] = list_words[k - 1];
          end
          list_words[pos] = op.value;
          list_len++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.removed_value = take_word(op.func == OP_POP_FRONT ? 0 : list_len - 1);
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // The first equal entry from the front is the one removed.
          found = 1'b0;
          pos = 0;
          for (int k = list_len - 1; k >= 0; k--) begin
            if (list_words[k] == op.value) begin
              found = 1'b1;
              pos = k;
            end
          end
          if (found) r.removed_value = take_word(pos);
          else r.status = STAT_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(list_len);
    return r;
  endfunction

  // Words that hit the extremes, collide often, or cover every bit.
  function automatic logic signed [31:0] random_word();
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5, 6: return 32'($urandom_range(15)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [2:0] func, input logic signed [31:0] value,
                         input bit fixed, input logic signed [31:0] removed,
                         input logic [1:0] status, input logic [4:0] count);
    op_row_t row;
    row.op.func = func;
    row.op.value = value;
    row.fixed = fixed;
    row.res.removed_value = removed;
    row.res.status = status;
    row.res.entry_count = count;
    directed_ops.push_back(row);
  endtask

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  // Offers one item after a random gap and records its expected result
  // at the edge where it is accepted.
  task automatic send_op(input in_item_t op, input bit fixed, input out_item_t fixed_res);
    out_item_t res;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_list_op(op);
    if (fixed) res = fixed_res;
    pending_results.push_back(res);
  endtask

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result removed=%0d status=%0d count=%0d",
                                 out_data.removed_value, out_data.status,
                                 out_data.entry_count));
      end else begin
        want = pending_results.pop_front();
        if (out_data.removed_value !== want.removed_value ||
            out_data.status !== want.status ||
            out_data.entry_count !== want.entry_count) begin
          report_failure($sformatf(
            "result mismatch: expected removed=%0d status=%0d count=%0d, got %0d %0d %0d",
            want.removed_value, want.status, want.entry_count,
            out_data.removed_value, out_data.status, out_data.entry_count));
        end
      end
    end
  end

  // Stimulus: directed items, then random items in phases of differing gaps and stalls.
  initial begin
    in_item_t op;
    int       roll;
    bit       filling;
    filling = 1'b1;

    // Empty list, spare codes, then a fill through every insert path.
    add_row(OP_POP_FRONT, 32'sd0, 1, 32'sd0, STAT_EMPTY, 5'd0);
    add_row(OP_POP_BACK, 32'sd0, 1, 32'sd0, STAT_EMPTY, 5'd0);
    add_row(OP_DELETE, 32'sd5, 1, 32'sd0, STAT_EMPTY, 5'd0);
    add_row(OP_SPARE_6, 32'sd0, 1, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SPARE_7, -32'sd1, 1, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SORTED_INSERT, 32'sd0, 1, 32'sd0, STAT_OK, 5'd1);
    add_row(OP_PUSH_FRONT, WORD_MIN, 1, 32'sd0, STAT_OK, 5'd2);
    add_row(OP_PUSH_BACK, WORD_MAX, 1, 32'sd0, STAT_OK, 5'd3);
    add_row(OP_SORTED_INSERT, -32'sd5, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SORTED_INSERT, WORD_MAX, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SORTED_INSERT, WORD_MIN, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SORTED_INSERT, 32'sd10, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_PUSH_BACK, -32'sd1, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SORTED_INSERT, 32'sd5, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SORTED_INSERT, -32'sd100, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_PUSH_FRONT, 32'sh5555_5555, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_PUSH_BACK, 32'shAAAA_AAAA, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_PUSH_FRONT, 32'sd1, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_SORTED_INSERT, 32'sd2, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_PUSH_BACK, 32'sd3, 0, 32'sd0, STAT_OK, 5'd0);
    add_row(OP_PUSH_FRONT, 32'sd4, 1, 32'sd0, STAT_OK, 5'd16);
    // Full list refuses inserts; missing and duplicated keys on delete.
    add_row(OP_PUSH_FRONT, 32'sd9, 1, 32'sd0, STAT_FULL, 5'd16);
    add_row(OP_SORTED_INSERT, 32'sd0, 1, 32'sd0, STAT_FULL, 5'd16);
    add_row(OP_DELETE, 32'sd12345, 1, 32'sd0, STAT_NOTFOUND, 5'd16);
    add_row(OP_DELETE, WORD_MIN, 1, WORD_MIN, STAT_OK, 5'd15);
    add_row(OP_POP_FRONT, 32'sd0, 0, 32'sd0, STAT_OK, 5'd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 19;
    stall_pct = 19;
    foreach (directed_ops[i]) begin
      send_op(directed_ops[i].op, directed_ops[i].fixed, directed_ops[i].res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case (n / PHASE_ITEMS)
          1: begin gap_pct = 80; stall_pct = 0; end
          2: begin gap_pct = 0; stall_pct = 80; end
          3: begin gap_pct = 19; stall_pct = 19; end
          default: begin gap_pct = 0; stall_pct = 0; end
        endcase
      end
      // Pick a fill or drain trend at random every 40 items so the list swings between empty and full.
      if (n % 40 == 0) filling = $urandom_range(1);
      roll = $urandom_range(99);
      op.value = random_word();
      if (roll < 3) begin
        op.func = 3'($urandom_range(7, 6));
        op.value = $urandom;
      end else if ((roll < 70) == filling) begin
        case ($urandom_range(3))
          0: op.func = OP_PUSH_FRONT;
          1: op.func = OP_PUSH_BACK;
          default: op.func = OP_SORTED_INSERT;
        endcase
      end else begin
        case ($urandom_range(3))
          0: op.func = OP_POP_FRONT;
          1: op.func = OP_POP_BACK;
          default: begin
            op.func = OP_DELETE;
            if (list_len > 0 && $urandom_range(9) < 7) begin
              op.value = list_words[$urandom_range(list_len - 1)];
            end
          end
        endcase
      end
      send_op(op, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_deque_sorted_list_unit test passed");
    end else begin
      $display("bounded_deque_sorted_list_unit test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("bounded_deque_sorted_list_unit test failed");
    $finish;
  end

endmodule
